/* hdl/left_right_lock_arbiter_defines.svh */
// ----------------------------------------------------------------------------
// left/right lock arbiter assertion macros
// shared helpers for concurrent checks on clk_i, optionally disabled by rst_ni
// ----------------------------------------------------------------------------
`ifndef LEFT_RIGHT_LOCK_ARBITER_DEFINES_SVH
`define LEFT_RIGHT_LOCK_ARBITER_DEFINES_SVH

// check outside reset
`define LRLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check at every edge, reset included
`define LRLA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/lrla_pkg.sv */
// ----------------------------------------------------------------------------
// lrla_pkg
// types, codes and helpers shared by the left/right lock arbiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrla_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned REQUESTERS      = 256;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned ACT_W           = 2;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned SIDE_W          = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_HALF_LOCK   = 2'd0,
    ACT_HALF_UNLOCK = 2'd1,
    ACT_FULL_LOCK   = 2'd2,
    ACT_FULL_UNLOCK = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED  = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_REJECTED = 3'd3,
    KIND_WOKEN    = 3'd4
  } kind_e;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_LEFT  = 2'd0,
    SIDE_RIGHT = 2'd1,
    SIDE_BOTH  = 2'd2,
    SIDE_NONE  = 2'd3
  } side_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_WAKE1,
    S_WAKE2
  } state_e;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_EVAL,
    STEP_WAKE1,
    STEP_WAKE2
  } step_e;

  typedef struct packed {
    step_e step;
    logic  ld_req;
    logic  ld_hd;
    logic  rd_next;
  } ctl_cmd_t;

  typedef struct packed {
    logic fire;
    logic more;
  } ctl_sts_t;

  typedef struct packed {
    logic            full;
    logic [ID_W-1:0] id;
  } entry_t;

  // requester id modulo REQUESTERS by shifted compare and subtract
  function automatic logic [ID_W-1:0] req_mod(logic [ID_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = ID_W - 1; k >= 0; k--) begin
      if (r >= (32'(REQUESTERS) << k)) begin
        r = r - (32'(REQUESTERS) << k);
      end
    end
    return r[ID_W-1:0];
  endfunction

endpackage

/* hdl/lrla_datapath.sv */
// ----------------------------------------------------------------------------
// lrla_datapath
// lock halves, waiter queue memory, request and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "left_right_lock_arbiter_defines.svh"

module lrla_datapath #(
  parameter int unsigned QUEUE_DEPTH = lrla_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lrla_pkg::ACT_W-1:0]    action_i,
  input  logic [lrla_pkg::ID_W-1:0]     requester_i,
  input  logic                          side_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [lrla_pkg::KIND_W-1:0]   result_kind_o,
  output logic [lrla_pkg::ID_W-1:0]     grant_requester_o,
  output logic [lrla_pkg::SIDE_W-1:0]   grant_side_o,
  output logic                          last_o,
  input  lrla_pkg::ctl_cmd_t            cmd_i,
  output lrla_pkg::ctl_sts_t            sts_o
);
  import lrla_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PTR_W-1:0] nxt(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  action_e          act_q;
  logic [ID_W-1:0]  id_q;
  logic             side_q;
  logic             left_q, left_d;
  logic             right_q, right_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  entry_t           mem [QUEUE_DEPTH];
  entry_t           rd_q;
  entry_t           hd_q;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;
  logic             hd_load;

  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q, kind;
  logic [ID_W-1:0]  out_id_q, o_id;
  side_e            out_side_q, o_side;
  logic             out_last_q;

  logic             out_free;
  logic             fire;
  logic             more;
  logic             enq, deq;
  logic             q_empty, q_full, other_busy;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = (cmd_i.step != STEP_NONE) && out_free;
  assign q_empty    = (cnt_q == '0);
  assign q_full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign other_busy = side_q ? left_q : right_q;
  assign rd_addr    = cmd_i.rd_next ? nxt(head_q) : head_q;

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    enq     = 1'b0;
    deq     = 1'b0;
    more    = 1'b0;
    hd_load = cmd_i.ld_hd;
    kind    = KIND_GRANTED;
    o_id    = id_q;
    o_side  = SIDE_NONE;
    if (fire) begin
      unique case (cmd_i.step)
        STEP_EVAL: begin
          unique case (act_q)
            ACT_HALF_LOCK: begin
              if ((left_q && right_q) || !q_empty) begin
                enq  = !q_full;
                kind = q_full ? KIND_REJECTED : KIND_QUEUED;
              end else if (!left_q) begin
                left_d = 1'b1;
                o_side = SIDE_LEFT;
              end else begin
                right_d = 1'b1;
                o_side  = SIDE_RIGHT;
              end
            end
            ACT_FULL_LOCK: begin
              if (left_q || right_q || !q_empty) begin
                enq  = !q_full;
                kind = q_full ? KIND_REJECTED : KIND_QUEUED;
              end else begin
                left_d  = 1'b1;
                right_d = 1'b1;
                o_side  = SIDE_BOTH;
              end
            end
            ACT_HALF_UNLOCK: begin
              if (side_q) begin
                right_d = 1'b0;
              end else begin
                left_d = 1'b0;
              end
              kind   = KIND_RELEASED;
              o_side = side_e'({1'b0, side_q});
              more   = !q_empty && (!hd_q.full || !other_busy);
            end
            ACT_FULL_UNLOCK: begin
              left_d  = 1'b0;
              right_d = 1'b0;
              kind    = KIND_RELEASED;
              o_side  = SIDE_BOTH;
              more    = !q_empty;
            end
            default: ;
          endcase
        end
        STEP_WAKE1: begin
          deq     = 1'b1;
          hd_load = 1'b1;
          kind    = KIND_WOKEN;
          o_id    = hd_q.id;
          if (hd_q.full) begin
            left_d  = 1'b1;
            right_d = 1'b1;
            o_side  = SIDE_BOTH;
          end else if (act_q == ACT_HALF_UNLOCK) begin
            if (side_q) begin
              right_d = 1'b1;
            end else begin
              left_d = 1'b1;
            end
            o_side = side_e'({1'b0, side_q});
          end else begin
            left_d = 1'b1;
            o_side = SIDE_LEFT;
            more   = (cnt_q >= CNT_W'(2)) && !rd_q.full;
          end
        end
        STEP_WAKE2: begin
          deq     = 1'b1;
          right_d = 1'b1;
          kind    = KIND_WOKEN;
          o_id    = hd_q.id;
          o_side  = SIDE_RIGHT;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    wr_en  = enq;
    if (enq) begin
      tail_d = nxt(tail_q);
      cnt_d  = cnt_q + CNT_W'(1);
    end else if (deq) begin
      head_d = nxt(head_q);
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= 1'b0;
      right_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      left_q      <= left_d;
      right_q     <= right_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // waiter queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= '{full: (act_q == ACT_FULL_LOCK), id: id_q};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      act_q  <= action_e'(action_i);
      id_q   <= req_mod(requester_i);
      side_q <= side_i;
    end
    if (hd_load) begin
      hd_q <= rd_q;
    end
    if (fire) begin
      out_kind_q <= kind;
      out_id_q   <= o_id;
      out_side_q <= o_side;
      out_last_q <= !more;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_kind_q;
  assign grant_requester_o = out_id_q;
  assign grant_side_o      = out_side_q;
  assign last_o            = out_last_q;
  assign sts_o.fire        = fire;
  assign sts_o.more        = more;

  `LRLA_ASSERT_ALWAYS(a_empty_ptrs, (cnt_q == '0) |-> (head_q == tail_q), "empty queue with pointers apart")
  `LRLA_ASSERT(a_no_idle_waiter, (cmd_i.step == STEP_NONE) |-> (left_q || right_q || cnt_q == '0), "waiter left behind with lock free")
  `LRLA_ASSERT(a_reject_full, (fire && kind == KIND_REJECTED) |-> (cnt_q == CNT_W'(QUEUE_DEPTH)), "reject with room in queue")

endmodule

/* hdl/lrla_ctrl.sv */
// ----------------------------------------------------------------------------
// lrla_ctrl
// request sequencer: accept, head fetch, evaluate and wake steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "left_right_lock_arbiter_defines.svh"

module lrla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output lrla_pkg::ctl_cmd_t cmd_o,
  input  lrla_pkg::ctl_sts_t sts_i
);
  import lrla_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_FETCH;
      S_FETCH: state_d = S_EVAL;
      S_EVAL:  if (sts_i.fire) state_d = sts_i.more ? S_WAKE1 : S_IDLE;
      S_WAKE1: if (sts_i.fire) state_d = sts_i.more ? S_WAKE2 : S_IDLE;
      S_WAKE2: if (sts_i.fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.step    = STEP_NONE;
    cmd_o.ld_req  = 1'b0;
    cmd_o.ld_hd   = 1'b0;
    cmd_o.rd_next = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.ld_req  = in_valid_i;
        cmd_o.rd_next = 1'b0;
      end
      S_FETCH: cmd_o.ld_hd = 1'b1;
      S_EVAL:  cmd_o.step = STEP_EVAL;
      S_WAKE1: cmd_o.step = STEP_WAKE1;
      S_WAKE2: cmd_o.step = STEP_WAKE2;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LRLA_ASSERT(a_wake2_order, (state_q == S_WAKE2) |-> ($past(state_q) == S_WAKE1 || $past(state_q) == S_WAKE2), "second wake without first")
  `LRLA_ASSERT(a_fetch_after_accept, (state_q == S_FETCH) |-> ($past(state_q) == S_IDLE && $past(in_valid_i)), "fetch without request")
  `LRLA_ASSERT(a_fire_in_step, sts_i.fire |-> (state_q == S_EVAL || state_q == S_WAKE1 || state_q == S_WAKE2), "result outside a step")

endmodule

/* hdl/left_right_lock_arbiter.sv */
// a request is accepted only in idle, once the last one and its wakes are done; it is
// registered, the head fetched, then it is evaluated into the output register
// the queue memory has one read port, so the head entry is fetched in its own step
// results stall in an output register while out_ready_i is low
// reset (rst_ni low, asynchronous): both halves free, queue empty, no result pending
// ----------------------------------------------------------------------------
// left_right_lock_arbiter
// two-half lock with a FIFO of half and full waiters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module left_right_lock_arbiter #(
  parameter int unsigned QUEUE_DEPTH = lrla_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lrla_pkg::ACT_W-1:0]    action_i,
  input  logic [lrla_pkg::ID_W-1:0]     requester_i,
  input  logic                          side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lrla_pkg::KIND_W-1:0]   result_kind_o,
  output logic [lrla_pkg::ID_W-1:0]     grant_requester_o,
  output logic [lrla_pkg::SIDE_W-1:0]   grant_side_o,
  output logic                          last_o
);
  import lrla_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lrla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lrla_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .action_i          (action_i),
    .requester_i       (requester_i),
    .side_i            (side_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .result_kind_o     (result_kind_o),
    .grant_requester_o (grant_requester_o),
    .grant_side_o      (grant_side_o),
    .last_o            (last_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule
